>>> sv/crs_pkg.sv
// Shared constants and stage payload types for the raster size pipeline.
package crs_pkg;

  localparam int DIM_W        = 16;
  localparam int LD_W         = 15;
  localparam int UNIT_W       = 2 * DIM_W;
  localparam int PROD_W       = LD_W + UNIT_W;
  localparam int Q_W          = LD_W;
  localparam int RES_W        = 16;

  localparam int ROT_FULL     = 360;
  localparam int ROT_QUARTER  = 90;
  localparam int ROT_HALF     = ROT_FULL / 2;
  // Unsigned view of the rotation is rot + 2**15; fold that bias into the match value.
  localparam int ROT_BIAS     = (1 << (DIM_W - 1)) % ROT_HALF;
  localparam int ROT_MATCH    = (ROT_QUARTER + ROT_BIAS) % ROT_HALF;
  localparam int ROT_TOP_K    = 8;
  localparam int ROT_PER_STG  = 3;
  localparam int ORI_STAGES   = 3;

  localparam int MIN_EVEN     = 2;
  localparam logic [LD_W-1:0] LD_RESET = LD_W'(512);

  typedef struct packed {
    logic [DIM_W-1:0] sw;
    logic [DIM_W-1:0] sh;
    logic [DIM_W-1:0] an;
    logic [DIM_W-1:0] ad;
    logic [DIM_W-1:0] rot;
    logic             err;
  } geo_t;

  typedef struct packed {
    logic [DIM_W-1:0] ow;
    logic [DIM_W-1:0] oh;
    logic [DIM_W-1:0] an;
    logic [DIM_W-1:0] ad;
    logic             err;
  } ori_t;

  typedef struct packed {
    logic [DIM_W-1:0]  ow;
    logic [DIM_W-1:0]  oh;
    logic [UNIT_W-1:0] wu;
    logic [UNIT_W-1:0] hu;
    logic              err;
  } unit_t;

  typedef struct packed {
    logic [DIM_W-1:0]  ow;
    logic [DIM_W-1:0]  oh;
    logic [UNIT_W-1:0] lng;
    logic [UNIT_W-1:0] sht;
    logic              eq;
    logic              hwide;
    logic              err;
  } sel_t;

  typedef struct packed {
    logic [DIM_W-1:0]      ow;
    logic [DIM_W-1:0]      oh;
    logic [UNIT_W-1:0]     lng;
    logic [LD_W+DIM_W-1:0] p_lo;
    logic [LD_W+DIM_W-1:0] p_hi;
    logic                  eq;
    logic                  hwide;
    logic                  err;
  } prod_t;

  typedef struct packed {
    logic [DIM_W-1:0]  ow;
    logic [DIM_W-1:0]  oh;
    logic [PROD_W-1:0] rem;
    logic [UNIT_W-1:0] d;
    logic [Q_W-1:0]    q;
    logic              eq;
    logic              hwide;
    logic              err;
  } div_t;

  typedef struct packed {
    logic [RES_W-1:0] rw;
    logic [RES_W-1:0] rh;
    logic [DIM_W-1:0] ow;
    logic [DIM_W-1:0] oh;
    logic             err;
  } res_t;

endpackage

>>> sv/crs_orient.sv
// Rotation reduction modulo 180 over three stages, then the axis swap.
module crs_orient (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  crs_pkg::geo_t in_geo,
  output logic          out_valid,
  input  logic          out_ready,
  output crs_pkg::ori_t out_ori
);
  import crs_pkg::*;

  logic [ORI_STAGES-1:0] v;
  geo_t                  pl [ORI_STAGES];
  logic [ORI_STAGES:0]   adv;
  logic [DIM_W-1:0]      u0;
  geo_t                  g0;
  logic                  swap;

  // Three conditional subtracts of 180 << k, k from top down.
  function automatic logic [DIM_W-1:0] rot_reduce(input logic [DIM_W-1:0] u, input int top);
    logic [DIM_W-1:0] x;
    logic [DIM_W:0]   m;
    x = u;
    for (int k = 0; k < ROT_PER_STG; k++) begin
      m = (DIM_W+1)'(ROT_HALF) << (top - k);
      if ({1'b0, x} >= m) begin
        x = DIM_W'({1'b0, x} - m);
      end
    end
    return x;
  endfunction

  function automatic geo_t reduce_stage(input geo_t g, input int top);
    geo_t y;
    y     = g;
    y.rot = rot_reduce(g.rot, top);
    return y;
  endfunction

  always_comb begin
    adv[ORI_STAGES] = out_ready;
    for (int i = ORI_STAGES - 1; i >= 0; i--) begin
      adv[i] = !v[i] || adv[i+1];
    end
  end

  assign in_ready = adv[0];
  assign u0       = {~in_geo.rot[DIM_W-1], in_geo.rot[DIM_W-2:0]};

  always_comb begin
    g0     = in_geo;
    g0.rot = u0;
    g0.err = (in_geo.sw == '0) || (in_geo.sh == '0) ||
             (in_geo.an == '0) || (in_geo.ad == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (adv[0]) v[0] <= in_valid;
      for (int i = 1; i < ORI_STAGES; i++) begin
        if (adv[i]) v[i] <= v[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      pl[0] <= reduce_stage(g0, ROT_TOP_K);
    end
    for (int i = 1; i < ORI_STAGES; i++) begin
      if (adv[i]) begin
        pl[i] <= reduce_stage(pl[i-1], ROT_TOP_K - ROT_PER_STG * i);
      end
    end
  end

  assign swap      = (pl[ORI_STAGES-1].rot == DIM_W'(ROT_MATCH));
  assign out_valid = v[ORI_STAGES-1];

  always_comb begin
    out_ori.ow  = swap ? pl[ORI_STAGES-1].sh : pl[ORI_STAGES-1].sw;
    out_ori.oh  = swap ? pl[ORI_STAGES-1].sw : pl[ORI_STAGES-1].sh;
    out_ori.an  = pl[ORI_STAGES-1].an;
    out_ori.ad  = pl[ORI_STAGES-1].ad;
    out_ori.err = pl[ORI_STAGES-1].err;
  end

endmodule

>>> sv/crs_units.sv
// Display units, long/short select and the scaled numerator, four stages.
module crs_units (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [crs_pkg::LD_W-1:0]  ld,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  crs_pkg::ori_t             in_ori,
  output logic                      out_valid,
  input  logic                      out_ready,
  output crs_pkg::div_t             out_div
);
  import crs_pkg::*;

  logic [3:0] v;
  logic [4:0] adv;
  unit_t      s1;
  sel_t       s2;
  prod_t      s3;
  div_t       s4;
  logic       hw;

  always_comb begin
    adv[4] = out_ready;
    for (int i = 3; i >= 0; i--) begin
      adv[i] = !v[i] || adv[i+1];
    end
  end

  assign in_ready = adv[0];
  assign hw       = s1.hu > s1.wu;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (adv[0]) v[0] <= in_valid;
      if (adv[1]) v[1] <= v[0];
      if (adv[2]) v[2] <= v[1];
      if (adv[3]) v[3] <= v[2];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s1.ow  <= in_ori.ow;
      s1.oh  <= in_ori.oh;
      s1.wu  <= in_ori.ow * in_ori.an;
      s1.hu  <= in_ori.oh * in_ori.ad;
      s1.err <= in_ori.err;
    end
    if (adv[1]) begin
      s2.ow    <= s1.ow;
      s2.oh    <= s1.oh;
      s2.lng   <= hw ? s1.hu : s1.wu;
      s2.sht   <= hw ? s1.wu : s1.hu;
      s2.eq    <= s1.hu == s1.wu;
      s2.hwide <= hw;
      s2.err   <= s1.err;
    end
    // Split the 15x32 product into two 15x16 halves.
    if (adv[2]) begin
      s3.ow    <= s2.ow;
      s3.oh    <= s2.oh;
      s3.lng   <= s2.lng;
      s3.p_lo  <= ld * s2.sht[DIM_W-1:0];
      s3.p_hi  <= ld * s2.sht[UNIT_W-1:DIM_W];
      s3.eq    <= s2.eq;
      s3.hwide <= s2.hwide;
      s3.err   <= s2.err;
    end
    if (adv[3]) begin
      s4.ow    <= s3.ow;
      s4.oh    <= s3.oh;
      s4.rem   <= PROD_W'(s3.p_lo) + (PROD_W'(s3.p_hi) << DIM_W);
      s4.d     <= s3.lng;
      s4.q     <= '0;
      s4.eq    <= s3.eq;
      s4.hwide <= s3.hwide;
      s4.err   <= s3.err;
    end
  end

  assign out_valid = v[3];
  assign out_div   = s4;

endmodule

>>> sv/crs_divide.sv
// Restoring divider, one quotient bit per stage, then even rounding and the result register.
module crs_divide (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [crs_pkg::LD_W-1:0]  ld,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  crs_pkg::div_t             in_div,
  output logic                      out_valid,
  input  logic                      out_ready,
  output crs_pkg::res_t             out_res
);
  import crs_pkg::*;

  logic [Q_W:0]     v;
  logic [Q_W+1:0]   adv;
  div_t             dv [Q_W];
  res_t             res;
  logic [RES_W-1:0] rnd;
  logic [RES_W-1:0] ldx;
  logic [Q_W-1:0]   qf;

  function automatic div_t div_step(input div_t x, input int b);
    div_t             y;
    logic [PROD_W-1:0] m;
    y = x;
    m = PROD_W'(x.d) << b;
    if (x.rem >= m) begin
      y.rem  = x.rem - m;
      y.q[b] = 1'b1;
    end
    return y;
  endfunction

  always_comb begin
    adv[Q_W+1] = out_ready;
    for (int i = Q_W; i >= 0; i--) begin
      adv[i] = !v[i] || adv[i+1];
    end
  end

  assign in_ready = adv[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (adv[0]) v[0] <= in_valid;
      for (int i = 1; i <= Q_W; i++) begin
        if (adv[i]) v[i] <= v[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) dv[0] <= div_step(in_div, Q_W - 1);
    for (int i = 1; i < Q_W; i++) begin
      if (adv[i]) dv[i] <= div_step(dv[i-1], Q_W - 1 - i);
    end
  end

  // Nearest even: odd quotient rounds up, below two clamps to two.
  assign qf  = dv[Q_W-1].q;
  assign ldx = RES_W'(ld);
  always_comb begin
    if (qf < Q_W'(MIN_EVEN)) begin
      rnd = RES_W'(MIN_EVEN);
    end else if (qf[0]) begin
      rnd = RES_W'(qf) + RES_W'(1);
    end else begin
      rnd = RES_W'(qf);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[Q_W]) begin
      if (dv[Q_W-1].err) begin
        res <= '{rw: '0, rh: '0, ow: '0, oh: '0, err: 1'b1};
      end else begin
        res.ow  <= dv[Q_W-1].ow;
        res.oh  <= dv[Q_W-1].oh;
        res.err <= 1'b0;
        if (dv[Q_W-1].eq) begin
          res.rw <= ldx;
          res.rh <= ldx;
        end else if (dv[Q_W-1].hwide) begin
          res.rw <= rnd;
          res.rh <= ldx;
        end else begin
          res.rw <= ldx;
          res.rh <= rnd;
        end
      end
    end
  end

  assign out_valid = v[Q_W];
  assign out_res   = res;

endmodule

>>> sv/canonical_raster_size_unit.sv
// Top level of the canonical raster size pipeline.
//
// Input stream s_axis: one source geometry per transfer, tdata holds stored width,
// stored height, aspect numerator, aspect denominator and signed rotation.
// Output stream m_axis: one result per input, tdata holds raster width and height
// and the oriented width and height; tuser carries the error flag.
// Configuration: cfg_wen writes cfg_wdata into the longest dimension register;
// write it only while the pipeline is empty.
// The pipeline has three rotation reduction stages, four stages for the
// display units and scaled numerator, fifteen divider stages (one quotient
// bit each) and one result register. One transfer is accepted every cycle
// unless stalled. Each stage holds its own valid bit and takes new data when
// empty or when the next stage advances, so a stalled receiver fills the
// pipeline before s_axis_tready drops, and no item is lost or repeated.
// Reset clears all valid bits and loads the longest dimension with 512.
module canonical_raster_size_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [15:0] frame_width, [31:16] frame_height, [47:32] aspect_num,
  // [63:48] aspect_den, [79:64] rotation
  input  logic [79:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [15:0] raster_width, [31:16] raster_height, [47:32] turned_width,
  // [63:48] turned_height
  output logic [63:0] m_axis_tdata,
  // [0] error_code
  output logic [0:0]  m_axis_tuser,
  input  logic        cfg_wen,
  input  logic [14:0] cfg_wdata
);
  import crs_pkg::*;

  logic [LD_W-1:0] longest_dimension;
  geo_t            geo;
  ori_t            ori;
  div_t            dvi;
  res_t            res;
  logic            ori_valid, ori_ready;
  logic            dvi_valid, dvi_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      longest_dimension <= LD_RESET;
    end else if (cfg_wen) begin
      longest_dimension <= cfg_wdata;
    end
  end

  always_comb begin
    geo.sw  = s_axis_tdata[15:0];
    geo.sh  = s_axis_tdata[31:16];
    geo.an  = s_axis_tdata[47:32];
    geo.ad  = s_axis_tdata[63:48];
    geo.rot = s_axis_tdata[79:64];
    geo.err = 1'b0;
  end

  crs_orient u_orient (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_geo    (geo),
    .out_valid (ori_valid),
    .out_ready (ori_ready),
    .out_ori   (ori)
  );

  crs_units u_units (
    .clk       (clk),
    .rst       (rst),
    .ld        (longest_dimension),
    .in_valid  (ori_valid),
    .in_ready  (ori_ready),
    .in_ori    (ori),
    .out_valid (dvi_valid),
    .out_ready (dvi_ready),
    .out_div   (dvi)
  );

  crs_divide u_divide (
    .clk       (clk),
    .rst       (rst),
    .ld        (longest_dimension),
    .in_valid  (dvi_valid),
    .in_ready  (dvi_ready),
    .in_div    (dvi),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (res)
  );

  assign m_axis_tdata = {res.oh, res.ow, res.rh, res.rw};
  assign m_axis_tuser = res.err;

`ifndef SYNTHESIS
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
    else $error("error result carries nonzero fields");

  a_long_side: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[0] |->
      res.rw == RES_W'(longest_dimension) || res.rh == RES_W'(longest_dimension))
    else $error("neither raster side equals the longest dimension");

  a_width_even: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[0] && res.rw != RES_W'(longest_dimension) |->
      !res.rw[0] && res.rw >= RES_W'(MIN_EVEN))
    else $error("derived raster width not even or below minimum");

  a_height_even: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[0] && res.rh != RES_W'(longest_dimension) |->
      !res.rh[0] && res.rh >= RES_W'(MIN_EVEN))
    else $error("derived raster height not even or below minimum");
`endif

endmodule
